/* rtl/gcd_pkg.sv */
package gcd_pkg;

  localparam int CordicStepsDefault = 24;
  localparam int CordicMax = 32;

  localparam int LatW = 24;
  localparam int LonW = 25;
  localparam int DistW = 23;

  // Q30 data path width: values stay well inside 36 bits.
  localparam int DW = 36;
  localparam int QW = 62;

  localparam logic signed [DW-1:0] Q30One = 36'sd1073741824;
  localparam logic signed [DW-1:0] Q30Pi = 36'sd3373259426;
  localparam logic signed [DW-1:0] Q30Pi2 = 36'sd1686629713;
  localparam logic signed [DW-1:0] Q30TwoPi = 36'sd6746518852;
  localparam logic signed [DW-1:0] CordGain = 36'sd652032874;

  localparam int QueueDepth = 4;
  localparam int QueueAw = 2;

  // Front-to-back record: three converted angles.
  typedef struct packed {
    logic signed [DW-1:0] la;
    logic signed [DW-1:0] lb;
    logic signed [DW-1:0] ld;
  } gcd_item_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [DW-1:0] atan_q30(input logic [4:0] i);
    logic signed [DW-1:0] v;
    begin
      case (i)
        5'd0: v = 36'sd843314857;
        5'd1: v = 36'sd497837829;
        5'd2: v = 36'sd263043837;
        5'd3: v = 36'sd133525159;
        5'd4: v = 36'sd67021687;
        5'd5: v = 36'sd33543516;
        5'd6: v = 36'sd16775851;
        5'd7: v = 36'sd8388437;
        5'd8: v = 36'sd4194283;
        5'd9: v = 36'sd2097149;
        5'd31: v = 36'sd1;
        default: v = 36'sd1 <<< (5'd30 - i);
      endcase
      atan_q30 = v;
    end
  endfunction

  // Fold an angle into [-pi/2, pi/2]; neg flags a negated cosine.
  function automatic logic [DW:0] fold_angle(input logic signed [DW-1:0] a);
    logic signed [DW-1:0] r;
    logic neg;
    begin
      r = a;
      neg = 1'b0;
      if (r > Q30Pi) r = r - Q30TwoPi;
      if (r < -Q30Pi) r = r + Q30TwoPi;
      if (r > Q30Pi) r = r - Q30TwoPi;
      if (r < -Q30Pi) r = r + Q30TwoPi;
      if (r > Q30Pi2) begin
        r = Q30Pi - r;
        neg = 1'b1;
      end else if (r < -Q30Pi2) begin
        r = -Q30Pi - r;
        neg = 1'b1;
      end
      fold_angle = {neg, r};
    end
  endfunction

endpackage

/* rtl/gcd_front.sv */
// Front end: degree to Q30 radian conversion, four pipeline stages.
module gcd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [gcd_pkg::LatW-1:0] in_lat_a,
  input  logic signed [gcd_pkg::LatW-1:0] in_lat_b,
  input  logic signed [gcd_pkg::LonW-1:0] in_lon_a,
  input  logic signed [gcd_pkg::LonW-1:0] in_lon_b,
  output logic                         fr_valid,
  input  logic                         fr_ready,
  output gcd_pkg::gcd_item_t           fr_item
);
  import gcd_pkg::*;

  // Reciprocal of 572958 scaled by 2^60, rounded down.
  localparam logic [47:0] RecipK = 48'd2012226907743;
  localparam int RecipSh = 60;
  localparam int HalfW = 26;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        adv1, adv2, adv3, adv4;
  logic signed [LonW:0] raw_w [4];
  logic [25:0] mag_w [4];
  logic [25:0] mag_r [4];
  logic [3:0]  sgn1_r, sgn2_r, sgn3_r;
  logic [51:0] numf_w [4];
  logic [51:0] num2_r [4];
  logic [51:0] num3_r [4];
  logic [67:0] plo_w [4];
  logic [67:0] phi_w [4];
  logic [67:0] plo_r [4];
  logic [67:0] phi_r [4];
  logic signed [DW-1:0] rad_w [4];
  logic signed [DW-1:0] rad_r [4];

  assign adv4 = !v4_r || fr_ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_full = !adv1;

  assign raw_w[0] = (LonW+1)'(in_lat_a);
  assign raw_w[1] = (LonW+1)'(in_lat_b);
  assign raw_w[2] = (LonW+1)'(in_lon_a);
  assign raw_w[3] = (LonW+1)'(in_lon_b);

  // Magnitudes of the four angles.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag_w[k] = raw_w[k][LonW] ? 26'(-raw_w[k]) : 26'(raw_w[k]);
    end
  end

  // Stage 2 input: numerator mag*163840000 + 286479 (below 2^52).
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      numf_w[k] = 52'(mag_r[k]) * 52'd163840000 + 52'd286479;
    end
  end

  // Stage 3 input: the reciprocal product in two halves of the numerator.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      plo_w[k] = 68'(num2_r[k][HalfW-1:0]) * 68'(RecipK);
      phi_w[k] = 68'(num2_r[k][51:HalfW]) * 68'(RecipK);
    end
  end

  // Quotient from the combined product, then one correction step.
  always_comb begin
    logic [93:0] p;
    logic [51:0] q, rem;
    for (int k = 0; k < 4; k++) begin
      p = (94'(phi_r[k]) << HalfW) + 94'(plo_r[k]);
      q = 52'(p >> RecipSh);
      rem = num3_r[k] - q * 52'd572958;
      if (rem >= 52'd572958) q = q + 52'd1;
      rad_w[k] = sgn3_r[k] ? -DW'(signed'({1'b0, q[34:0]}))
                           : DW'(signed'({1'b0, q[34:0]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_push;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
    if (adv1) begin
      for (int k = 0; k < 4; k++) begin
        mag_r[k] <= mag_w[k];
        sgn1_r[k] <= raw_w[k][LonW];
      end
    end
    if (adv2) begin
      for (int k = 0; k < 4; k++) num2_r[k] <= numf_w[k];
      sgn2_r <= sgn1_r;
    end
    if (adv3) begin
      for (int k = 0; k < 4; k++) begin
        num3_r[k] <= num2_r[k];
        plo_r[k] <= plo_w[k];
        phi_r[k] <= phi_w[k];
      end
      sgn3_r <= sgn2_r;
    end
    if (adv4) begin
      for (int k = 0; k < 4; k++) rad_r[k] <= rad_w[k];
    end
  end

  assign fr_valid = v4_r;
  assign fr_item.la = rad_r[0];
  assign fr_item.lb = rad_r[1];
  assign fr_item.ld = rad_r[3] - rad_r[2];
endmodule

/* rtl/gcd_queue.sv */
// Short queue between front and back ends.
module gcd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  gcd_pkg::gcd_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output gcd_pkg::gcd_item_t rd_item
);
  import gcd_pkg::*;

  gcd_item_t mem_r [QueueDepth];
  logic [QueueAw-1:0] wp_r, rp_r;
  logic [QueueAw:0]   cnt_r;
  logic wr_go, rd_go;

  assign wr_ready = cnt_r != (QueueAw+1)'(QueueDepth);
  assign rd_valid = cnt_r != '0;
  assign wr_go = wr_valid && wr_ready;
  assign rd_go = rd_valid && rd_ready;
  assign rd_item = mem_r[rp_r];

  // Pointer and count update on each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_go) wp_r <= wp_r + 1'b1;
      if (rd_go) rp_r <= rp_r + 1'b1;
      if (wr_go && !rd_go) cnt_r <= cnt_r + 1'b1;
      else if (rd_go && !wr_go) cnt_r <= cnt_r - 1'b1;
    end
    if (wr_go) mem_r[wp_r] <= wr_item;
  end
endmodule

/* rtl/gcd_back.sv */
// Back end: CORDIC sin/cos, products, square root, acos, scaling.
module gcd_back #(
  parameter int CORDIC_STEPS = gcd_pkg::CordicStepsDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       unit_sel,
  input  logic                       bk_valid,
  output logic                       bk_ready,
  input  gcd_pkg::gcd_item_t         bk_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gcd_pkg::DistW-1:0]  out_dist
);
  import gcd_pkg::*;

  localparam int NS = (CORDIC_STEPS < CordicMax) ? CORDIC_STEPS : CordicMax;
  localparam int SqSteps = 31;
  // Registers: fold, NS rotate, 3 product, clamp, SqSteps sqrt, prep,
  // NS vector, one plain stage, 2 scale. PL is the index of the last.
  localparam int PL = 1 + NS + 3 + 1 + SqSteps + 1 + NS + 2;

  typedef struct packed {
    logic signed [DW-1:0] x0, y0, z0;
    logic signed [DW-1:0] x1, y1, z1;
    logic signed [DW-1:0] x2, y2, z2;
    logic [2:0] neg;
    logic signed [DW-1:0] u;
    logic [QW-1:0] rem;
    logic [31:0]   root;
    logic [63:0]   prod;
    logic          us;
  } gcd_stage_t;

  gcd_stage_t st_r [PL+1];
  logic [PL:0] v_r;
  logic adv;

  // Output register with one skid-free stall: the whole pipe stalls.
  assign adv = !v_r[PL] || out_ready;
  assign bk_ready = adv;
  assign out_valid = v_r[PL];

  gcd_stage_t nx [PL+1];

  always_comb begin
    logic [DW:0] f0, f1, f2;
    logic signed [DW-1:0] dx, dy, a, m1, cc;
    logic signed [71:0] p;
    logic [QW-1:0] t;
    logic [4:0] ii;
    int s;
    nx[0] = '0;
    f0 = fold_angle(bk_item.la);
    f1 = fold_angle(bk_item.lb);
    f2 = fold_angle(bk_item.ld);
    nx[0].x0 = CordGain;
    nx[0].x1 = CordGain;
    nx[0].x2 = CordGain;
    nx[0].z0 = f0[DW-1:0];
    nx[0].z1 = f1[DW-1:0];
    nx[0].z2 = f2[DW-1:0];
    nx[0].neg = {f2[DW], f1[DW], f0[DW]};
    nx[0].us = unit_sel;
    for (int k = 1; k <= PL; k++) nx[k] = st_r[k-1];

    // Rotation stages, three lanes.
    for (int i = 0; i < NS; i++) begin
      s = 1 + i;
      ii = 5'(i);
      a = atan_q30(ii);
      if (st_r[s-1].z0 >= 0) begin
        nx[s].x0 = st_r[s-1].x0 - (st_r[s-1].y0 >>> i);
        nx[s].y0 = st_r[s-1].y0 + (st_r[s-1].x0 >>> i);
        nx[s].z0 = st_r[s-1].z0 - a;
      end else begin
        nx[s].x0 = st_r[s-1].x0 + (st_r[s-1].y0 >>> i);
        nx[s].y0 = st_r[s-1].y0 - (st_r[s-1].x0 >>> i);
        nx[s].z0 = st_r[s-1].z0 + a;
      end
      if (st_r[s-1].z1 >= 0) begin
        nx[s].x1 = st_r[s-1].x1 - (st_r[s-1].y1 >>> i);
        nx[s].y1 = st_r[s-1].y1 + (st_r[s-1].x1 >>> i);
        nx[s].z1 = st_r[s-1].z1 - a;
      end else begin
        nx[s].x1 = st_r[s-1].x1 + (st_r[s-1].y1 >>> i);
        nx[s].y1 = st_r[s-1].y1 - (st_r[s-1].x1 >>> i);
        nx[s].z1 = st_r[s-1].z1 + a;
      end
      if (st_r[s-1].z2 >= 0) begin
        nx[s].x2 = st_r[s-1].x2 - (st_r[s-1].y2 >>> i);
        nx[s].z2 = st_r[s-1].z2 - a;
      end else begin
        nx[s].x2 = st_r[s-1].x2 + (st_r[s-1].y2 >>> i);
        nx[s].z2 = st_r[s-1].z2 + a;
      end
      nx[s].y2 = (st_r[s-1].z2 >= 0) ? st_r[s-1].y2 + (st_r[s-1].x2 >>> i)
                                     : st_r[s-1].y2 - (st_r[s-1].x2 >>> i);
    end

    // Products: ca*cb and sa*sb, then times cd, then sum.
    s = NS + 1;
    m1 = st_r[s-1].neg[0] ? -st_r[s-1].x0 : st_r[s-1].x0;
    cc = st_r[s-1].neg[1] ? -st_r[s-1].x1 : st_r[s-1].x1;
    p = 72'(m1) * 72'(cc) + 72'sd536870912;
    nx[s].x0 = DW'(p >>> 30);
    p = 72'(st_r[s-1].y0) * 72'(st_r[s-1].y1) + 72'sd536870912;
    nx[s].y0 = DW'(p >>> 30);
    nx[s].x2 = st_r[s-1].neg[2] ? -st_r[s-1].x2 : st_r[s-1].x2;
    s = NS + 2;
    p = 72'(st_r[s-1].x0) * 72'(st_r[s-1].x2) + 72'sd536870912;
    nx[s].x0 = DW'(p >>> 30);
    s = NS + 3;
    nx[s].u = st_r[s-1].y0 + st_r[s-1].x0;
    // Clamp and form 2^60 - u^2.
    s = NS + 4;
    cc = st_r[s-1].u;
    if (cc > Q30One) cc = Q30One;
    if (cc < -Q30One) cc = -Q30One;
    nx[s].u = cc;
    p = 72'(cc) * 72'(cc);
    nx[s].rem = QW'((72'sd1 <<< 60) - p);
    nx[s].root = '0;

    // Square root, one result bit a stage: trial is 2*root*b + b^2.
    for (int j = 0; j < SqSteps; j++) begin
      s = NS + 5 + j;
      t = (QW'(st_r[s-1].root) << (31 - j)) + (QW'(1) << (2 * (30 - j)));
      if (st_r[s-1].rem >= t) begin
        nx[s].rem = st_r[s-1].rem - t;
        nx[s].root = st_r[s-1].root | (32'd1 << (30 - j));
      end
    end

    // Vectoring setup.
    s = NS + 5 + SqSteps;
    if (st_r[s-1].u < 0) begin
      nx[s].x0 = DW'(st_r[s-1].root);
      nx[s].y0 = -st_r[s-1].u;
      nx[s].z0 = Q30Pi2;
    end else begin
      nx[s].x0 = st_r[s-1].u;
      nx[s].y0 = DW'(st_r[s-1].root);
      nx[s].z0 = '0;
    end

    for (int i = 0; i < NS; i++) begin
      s = NS + 6 + SqSteps + i;
      ii = 5'(i);
      a = atan_q30(ii);
      dx = st_r[s-1].y0 >>> i;
      dy = st_r[s-1].x0 >>> i;
      if (st_r[s-1].y0 > 0) begin
        nx[s].x0 = st_r[s-1].x0 + dx;
        nx[s].y0 = st_r[s-1].y0 - dy;
        nx[s].z0 = st_r[s-1].z0 + a;
      end else begin
        nx[s].x0 = st_r[s-1].x0 - dx;
        nx[s].y0 = st_r[s-1].y0 + dy;
        nx[s].z0 = st_r[s-1].z0 - a;
      end
    end

    // Scale by radius times 256, then divide by 10*2^30 with rounding.
    s = PL - 1;
    cc = (st_r[s-1].z0 < 0) ? '0 : st_r[s-1].z0;
    nx[s].prod = 64'(cc) * (st_r[s-1].us ? 64'd16329728 : 64'd10145280)
                 + 64'd5368709120;
    s = PL;
    begin
      logic [127:0] qq;
      logic [63:0] q;
      // The shifted value stays far below 2^34, so the divide by 5 is exact.
      qq = 128'(st_r[s-1].prod >> 31) * 128'd3435973837;
      q = 64'(qq >> 34);
      nx[s].prod = (q > 64'h7FFFFF) ? 64'h7FFFFF : q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[PL-1:0], bk_valid};
    if (adv) begin
      for (int k = 0; k <= PL; k++) st_r[k] <= nx[k];
    end
  end

  assign out_dist = st_r[PL].prod[DistW-1:0];
endmodule

/* rtl/great_circle_distance_unit.sv */
// Channel  | Ports                                | Transfer when
// input    | in_push, in_full, in_lat_*, in_lon_* | in_push && !in_full
// result   | out_empty, out_pop, out_distance     | out_pop && !out_empty
// config   | cfg_valid, cfg_ready, cfg_data       | cfg_valid && cfg_ready
// One pair per cycle while nothing stalls; a result passes through the four front
// stages, the queue, the two unrolled CORDIC pipelines and the 31-stage square
// root on its way from the input transfer to the ports.
// Reset is synchronous on rst_n and clears valid bits and unit_select.
// A held result stalls the back pipe; the queue then fills and sets in_full.
module great_circle_distance_unit #(
  parameter int CORDIC_STEPS = gcd_pkg::CordicStepsDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic signed [gcd_pkg::LatW-1:0] in_lat_a,
  input  logic signed [gcd_pkg::LatW-1:0] in_lat_b,
  input  logic signed [gcd_pkg::LonW-1:0] in_lon_a,
  input  logic signed [gcd_pkg::LonW-1:0] in_lon_b,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [gcd_pkg::DistW-1:0]       out_distance,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);
  import gcd_pkg::*;

  logic unit_select_r;
  logic fr_valid, fr_ready, bk_valid, bk_ready, o_valid;
  gcd_item_t fr_item, bk_item;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) unit_select_r <= 1'b0;
    else if (cfg_valid) unit_select_r <= cfg_data;
  end

  gcd_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_lat_a, .in_lat_b, .in_lon_a,
    .in_lon_b, .fr_valid, .fr_ready, .fr_item
  );

  gcd_queue u_queue (
    .clk, .rst_n, .wr_valid(fr_valid), .wr_ready(fr_ready), .wr_item(fr_item),
    .rd_valid(bk_valid), .rd_ready(bk_ready), .rd_item(bk_item)
  );

  gcd_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .unit_sel(unit_select_r), .bk_valid, .bk_ready, .bk_item,
    .out_valid(o_valid), .out_ready(out_pop), .out_dist(out_distance)
  );

  assign out_empty = !o_valid;
endmodule
